// ----- rtl/array_linked_list_with_free_list_assert.svh -----
// assertion macros shared by the checker
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_ASSERT_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_ASSERT_SVH

// property that holds in the same cycle
`define ALFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ALFL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/alfl_pkg.sv -----
`timescale 1ns / 1ps

package alfl_pkg;

  // command modes
  localparam logic [2:0] MODE_HEAD = 3'd0;
  localparam logic [2:0] MODE_TAIL = 3'd1;
  localparam logic [2:0] MODE_SORT = 3'd2;
  localparam logic [2:0] MODE_DEL  = 3'd3;
  localparam logic [2:0] MODE_WALK = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // most words one walk emits
  localparam int unsigned WALK_CAP   = 8;
  localparam int unsigned WALK_CNT_W = $clog2(WALK_CAP);

  typedef enum logic [1:0] {
    RD_FREE,
    RD_HEAD,
    RD_NEXT
  } rd_src_e;

  typedef enum logic [2:0] {
    EM_FULL,
    EM_MISS,
    EM_EMPTY,
    EM_INS,
    EM_DEL,
    EM_WALK
  } emit_sel_e;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    rd_src_e   rd_src;
    logic      pop_free;
    logic      set_cur_head;
    logic      advance;
    logic      wr_node;
    logic      wr_prev_idx;
    logic      head_idx;
    logic      mark_free;
    logic      unlink;
    logic      emit;
    emit_sel_e emit_sel;
  } alfl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       free_null;
    logic       head_null;
    logic       prev_null;
    logic       nxt_null;
    logic       byte_ge;
    logic       byte_eq;
    logic       walk_last;
    logic       out_free;
  } alfl_sts_t;

endpackage

// ----- rtl/alfl_ram.sv -----
`timescale 1ns / 1ps

module alfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/alfl_ctrl.sv -----
`timescale 1ns / 1ps

module alfl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  alfl_pkg::alfl_sts_t sts_i,
  output alfl_pkg::alfl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_LINK2 = 3'd5;
  localparam logic [2:0] S_DEL   = 3'd6;

  logic [2:0] state_q, state_d;
  alfl_pkg::alfl_cmd_t cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.mode) inside
          alfl_pkg::MODE_HEAD, alfl_pkg::MODE_TAIL, alfl_pkg::MODE_SORT: begin
            if (sts_i.free_null) begin
              if (sts_i.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = alfl_pkg::EM_FULL;
                state_d      = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = alfl_pkg::RD_FREE;
              state_d    = S_ALLOC;
            end
          end
          alfl_pkg::MODE_DEL, alfl_pkg::MODE_WALK: begin
            if (sts_i.head_null) begin
              if (sts_i.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = (sts_i.mode == alfl_pkg::MODE_DEL) ?
                               alfl_pkg::EM_MISS : alfl_pkg::EM_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              cmd.set_cur_head = 1'b1;
              cmd.rd_en        = 1'b1;
              cmd.rd_src       = alfl_pkg::RD_HEAD;
              state_d          = S_CHK;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd.pop_free     = 1'b1;
        cmd.set_cur_head = 1'b1;
        if ((sts_i.mode == alfl_pkg::MODE_HEAD) || sts_i.head_null) begin
          state_d = S_LINK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = alfl_pkg::RD_HEAD;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        unique case (sts_i.mode) inside
          alfl_pkg::MODE_TAIL, alfl_pkg::MODE_SORT: begin
            if ((sts_i.mode == alfl_pkg::MODE_SORT) && sts_i.byte_ge) begin
              state_d = S_LINK;
            end else begin
              cmd.advance = 1'b1;
              if (sts_i.nxt_null) begin
                state_d = S_LINK;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = alfl_pkg::RD_NEXT;
              end
            end
          end
          alfl_pkg::MODE_DEL: begin
            if (sts_i.byte_eq) begin
              cmd.mark_free = 1'b1;
              state_d       = S_DEL;
            end else if (sts_i.nxt_null) begin
              if (sts_i.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = alfl_pkg::EM_MISS;
                state_d      = S_IDLE;
              end
            end else begin
              cmd.advance = 1'b1;
              cmd.rd_en   = 1'b1;
              cmd.rd_src  = alfl_pkg::RD_NEXT;
            end
          end
          alfl_pkg::MODE_WALK: begin
            if (sts_i.out_free) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = alfl_pkg::EM_WALK;
              if (sts_i.walk_last) begin
                state_d = S_IDLE;
              end else begin
                cmd.advance = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_src  = alfl_pkg::RD_NEXT;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_LINK: begin
        if (!sts_i.prev_null) begin
          cmd.wr_node = 1'b1;
          state_d     = S_LINK2;
        end else if (sts_i.out_free) begin
          cmd.wr_node  = 1'b1;
          cmd.head_idx = 1'b1;
          cmd.emit     = 1'b1;
          cmd.emit_sel = alfl_pkg::EM_INS;
          state_d      = S_IDLE;
        end
      end
      S_LINK2: begin
        if (sts_i.out_free) begin
          cmd.wr_prev_idx = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_sel    = alfl_pkg::EM_INS;
          state_d         = S_IDLE;
        end
      end
      S_DEL: begin
        if (sts_i.out_free) begin
          cmd.unlink   = 1'b1;
          cmd.emit     = 1'b1;
          cmd.emit_sel = alfl_pkg::EM_DEL;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/alfl_dp.sv -----
`timescale 1ns / 1ps

module alfl_dp #(
  parameter int unsigned NODES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0]                     mode_i,
  input  logic [7:0]                     value_i,
  input  alfl_pkg::alfl_cmd_t            cmd_i,
  output alfl_pkg::alfl_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [$clog2(NODES+1)-1:0]     slot_o,
  output logic [7:0]                     item_value_o,
  output logic                           last_o
);

  localparam int unsigned IDX_W = $clog2(NODES + 1);
  localparam int unsigned AW    = $clog2(NODES);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

  function automatic logic is_nd(logic [IDX_W-1:0] x);
    return x < NIL;
  endfunction

  logic [2:0]       mode_q;
  logic [7:0]       val_q;
  logic [IDX_W-1:0] list_head_q, free_head_q, cur_q, prev_q, idx_q, saved_q;
  logic [alfl_pkg::WALK_CNT_W-1:0] k_q;
  logic [NODES-1:0] nv_q;
  logic [AW-1:0]    rd_addr_q;
  logic             rd_nv_q;

  logic             out_valid_q, last_q;
  logic [1:0]       status_q;
  logic [IDX_W-1:0] slot_q;
  logic [7:0]       item_q;

  logic             last_d;
  logic [1:0]       status_d;
  logic [IDX_W-1:0] slot_d;
  logic [7:0]       item_d;

  logic [IDX_W-1:0] rd_idx, next_rd, nxt_norm, nram_rdata, nwdata;
  logic [AW-1:0]    rd_addr, nwaddr;
  logic             nwe, out_free, walk_last;
  logic [7:0]       byte_rd;

  // link memory read: stored value once written, else its reset chain
  assign next_rd  = rd_nv_q ? nram_rdata :
                    ((rd_addr_q == '0) ? NIL : IDX_W'(rd_addr_q) - IDX_W'(1));
  assign nxt_norm = is_nd(next_rd) ? next_rd : NIL;

  always_comb begin
    case (cmd_i.rd_src)
      alfl_pkg::RD_FREE: rd_idx = free_head_q;
      alfl_pkg::RD_HEAD: rd_idx = list_head_q;
      alfl_pkg::RD_NEXT: rd_idx = next_rd;
      default:           rd_idx = next_rd;
    endcase
  end
  assign rd_addr = rd_idx[AW-1:0];

  always_comb begin
    nwe    = 1'b0;
    nwaddr = cur_q[AW-1:0];
    nwdata = free_head_q;
    if (cmd_i.mark_free) begin
      nwe = 1'b1;
    end else if (cmd_i.wr_node) begin
      nwe    = 1'b1;
      nwaddr = idx_q[AW-1:0];
      nwdata = cur_q;
    end else if (cmd_i.wr_prev_idx) begin
      nwe    = 1'b1;
      nwaddr = prev_q[AW-1:0];
      nwdata = idx_q;
    end else if (cmd_i.unlink && is_nd(prev_q)) begin
      nwe    = 1'b1;
      nwaddr = prev_q[AW-1:0];
      nwdata = saved_q;
    end
  end

  alfl_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (nwaddr),
    .wdata_i (nwdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nram_rdata)
  );

  alfl_ram #(.WIDTH(8), .DEPTH(NODES)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_node),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (val_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (byte_rd)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign walk_last = !is_nd(next_rd) ||
                     (k_q == alfl_pkg::WALK_CNT_W'(alfl_pkg::WALK_CAP - 1));

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.free_null = !is_nd(free_head_q);
    sts_o.head_null = !is_nd(list_head_q);
    sts_o.prev_null = !is_nd(prev_q);
    sts_o.nxt_null  = !is_nd(next_rd);
    sts_o.byte_ge   = (byte_rd >= val_q);
    sts_o.byte_eq   = (byte_rd == val_q);
    sts_o.walk_last = walk_last;
    sts_o.out_free  = out_free;
  end

  // result word contents for the selected kind
  always_comb begin
    status_d = alfl_pkg::ST_OK;
    slot_d   = NIL;
    item_d   = val_q;
    last_d   = 1'b1;
    case (cmd_i.emit_sel)
      alfl_pkg::EM_FULL:  status_d = alfl_pkg::ST_FULL;
      alfl_pkg::EM_MISS:  status_d = alfl_pkg::ST_MISS;
      alfl_pkg::EM_EMPTY: status_d = alfl_pkg::ST_EMPTY;
      alfl_pkg::EM_INS:   slot_d   = idx_q;
      alfl_pkg::EM_DEL:   slot_d   = cur_q;
      alfl_pkg::EM_WALK: begin
        slot_d = cur_q;
        item_d = byte_rd;
        last_d = walk_last;
      end
      default: status_d = alfl_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_head_q <= NIL;
      free_head_q <= IDX_W'(NODES - 1);
      nv_q        <= '0;
      rd_nv_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        k_q <= '0;
      end else if (cmd_i.emit && (cmd_i.emit_sel == alfl_pkg::EM_WALK)) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.pop_free) begin
        free_head_q <= next_rd;
      end
      if (cmd_i.unlink) begin
        free_head_q <= cur_q;
        if (!is_nd(prev_q)) begin
          list_head_q <= saved_q;
        end
      end
      if (cmd_i.head_idx) begin
        list_head_q <= idx_q;
      end
      if (nwe) begin
        nv_q[nwaddr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_nv_q <= nv_q[rd_addr];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      val_q  <= value_i;
    end
    if (cmd_i.rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd_i.pop_free) begin
      idx_q <= free_head_q;
    end
    if (cmd_i.set_cur_head) begin
      cur_q  <= list_head_q;
      prev_q <= NIL;
    end else if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= nxt_norm;
    end
    if (cmd_i.mark_free) begin
      saved_q <= nxt_norm;
    end
    if (cmd_i.emit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      item_q   <= item_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign item_value_o = item_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/array_linked_list_with_free_list.sv -----
// Array-backed singly linked list of bytes with a free list. A pool of NODES nodes, each a byte
// and a link, sits in two small RAMs; free nodes are chained from a free head and the used ones
// form one list from the list head (a link equal to NODES is null). mode_i selects insert at
// head, insert at tail, insert in ascending order, delete first match, or walk; modes five to
// seven return nothing. Inserts and deletes return one word with status (ok, no free node, byte
// not found) and the node index used or freed; a walk returns one word per element with last_o
// on the tail element, at most eight words, or a single "list empty" word. One command is in
// work at a time. An insert into a full pool emits its "no free node" word from dispatch; else
// an insert takes a node from the free list, a tail or sorted insert then walks the list to
// its place, and the new node's link is written, together with the list head or, behind an
// existing node, with the predecessor's link in a further step. A delete searches node by
// node, frees the match and unlinks it; a walk emits one word per cycle unless a held result
// word stalls it. The next command word is taken only after the final result word is loaded.
// The single read port of the link memory, one node per cycle, sets the traversal pace; a held
// result word stalls the sequencer at its emitting step. No clearing pass is needed after
// reset; the reset link chain is served by per-node written flags.
`timescale 1ns / 1ps

module array_linked_list_with_free_list #(
  parameter int unsigned NODES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command word
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 mode_i,
  input  logic [7:0]                 value_i,
  // result word
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [$clog2(NODES+1)-1:0] slot_o,
  output logic [7:0]                 item_value_o,
  output logic                       last_o
);

  // command and status between sequencer and datapath
  alfl_pkg::alfl_cmd_t cmd;
  alfl_pkg::alfl_sts_t sts;

  // sequencer: dispatch, allocate, traverse, relink, emit
  alfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // node memories, head pointers, cursor and the result register
  alfl_dp #(.NODES(NODES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .item_value_o (item_value_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/alfl_checker.sv -----
`timescale 1ns / 1ps
`include "array_linked_list_with_free_list_assert.svh"

module alfl_checker #(
  parameter int unsigned NODES = 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [$clog2(NODES+1)-1:0] slot_o,
  input logic                       last_o
);

  localparam int unsigned IDX_W = $clog2(NODES + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

  logic err_word, ok_word;

  assign err_word = out_valid_o && (status_o != alfl_pkg::ST_OK);
  assign ok_word  = out_valid_o && (status_o == alfl_pkg::ST_OK);

  // a waiting word is not withdrawn
  `ALFL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result word dropped")

  // one command in work at a time
  `ALFL_ASSERT_NEXT(a_one_cmd, in_valid_i && in_ready_o, !in_ready_o, "second word taken early")

  // failures carry no node and end the command
  `ALFL_ASSERT(a_err_form, !err_word || ((slot_o == NIL) && last_o), "bad error word")

  // success names a real node
  `ALFL_ASSERT(a_ok_slot, !ok_word || (slot_o < NIL), "ok word without node")

endmodule

bind array_linked_list_with_free_list alfl_checker #(.NODES(NODES)) u_alfl_checker (.*);
